@@ hw/rtl/text_list_tokenizer_classifier_assert.svh @@
// Assertion macros used by the tokenizer top level
`ifndef TEXT_LIST_TOKENIZER_CLASSIFIER_ASSERT_SVH
`define TEXT_LIST_TOKENIZER_CLASSIFIER_ASSERT_SVH

// checked only out of reset
`define TLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TLC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tlc_pkg.sv @@
// Shared types, codes and constants of the text list tokenizer
package tlc_pkg;

	localparam int DEPTH_BITS_DEF  = 8;
	localparam int LENGTH_BITS_DEF = 8;

	// result queue
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = QPTR_BITS + 1;

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_LINE_END  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		CLS_INT    = 4'd0,
		CLS_FLOAT  = 4'd1,
		CLS_LIST   = 4'd2,
		CLS_VOCAB  = 4'd3,
		CLS_BLOB   = 4'd4,
		CLS_STRING = 4'd5,
		CLS_TRUE   = 4'd6,
		CLS_FALSE  = 4'd7,
		CLS_NULL   = 4'd8
	} class_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] WORD_NULL  [4] = '{"n", "u", "l", "l"};
	localparam logic [7:0] WORD_TRUE  [4] = '{"t", "r", "u", "e"};
	localparam logic [7:0] WORD_FALSE [5] = '{"f", "a", "l", "s", "e"};

	typedef struct packed {
		kind_t      item_kind;
		logic [7:0] token_char;
		class_t     token_class;
		logic       end_of_line;
		logic       balanced;
	} result_t;

	// up to two results produced by one character
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [QCNT_BITS-1:0] level;
		logic                 room2;
	} qstat_t;

endpackage

@@ hw/rtl/tlc_if.sv @@
// Character input and result output channel interfaces
interface tlc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       line_end;

	modport source (output valid, output text_char, output line_end, input ready);
	modport sink (input valid, input text_char, input line_end, output ready);
endinterface

interface tlc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] item_kind;
	logic [7:0] token_char;
	logic [3:0] token_class;
	logic       end_of_line;
	logic       balanced;

	modport source (output valid, output item_kind, output token_char, output token_class,
		output end_of_line, output balanced, input ready);
	modport sink (input valid, input item_kind, input token_char, input token_class,
		input end_of_line, input balanced, output ready);
endinterface

@@ hw/rtl/text_list_tokenizer_classifier.sv @@
// Text list tokenizer and classifier: top level
//
// chars channel: one byte of a text line per beat, line_end set on the last
// byte. results channel: one result per beat, either a token byte, a token
// end with its class, or a line end without a token. A byte yields at most
// one result, the last byte of a line up to two (the line closing result
// always carries end_of_line and balanced).
// A taken byte waits in the input register until the queue has room; it is
// then processed and its first result is offered from a four entry queue.
// Throughput: one byte per cycle while results are taken every cycle; a
// line end needing two results costs one extra output beat. The queue
// level sets ready: the processing register moves only when at least two free
// entries remain.
// Reset clears all tokenizer state (no quote, zero depths, no token) and
// empties the queue. If the receiver stalls, results wait in the queue and
// chars.ready drops once the queue cannot take another two results.
`include "text_list_tokenizer_classifier_assert.svh"

module text_list_tokenizer_classifier import tlc_pkg::*; #(
	parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tlc_in_if.sink    chars,
	tlc_out_if.source results
);

	logic       v_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       adv;
	push_t      push;
	qstat_t     qstat;
	result_t    head;

	assign adv         = v_s1 && qstat.room2;
	assign chars.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (chars.ready)
			v_s1 <= chars.valid;
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.text_char;
			end_s1  <= chars.line_end;
		end
	end

	tlc_core #(
		.DEPTH_BITS (DEPTH_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.text_char(char_s1),
		.line_end (end_s1),
		.push     (push)
	);

	tlc_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (adv),
		.push    (push),
		.rd_en   (results.ready),
		.rd_valid(results.valid),
		.rd_data (head),
		.stat    (qstat)
	);

	assign results.item_kind   = head.item_kind;
	assign results.token_char  = head.token_char;
	assign results.token_class = head.token_class;
	assign results.end_of_line = head.end_of_line;
	assign results.balanced    = head.balanced;

	// a stalled byte stays put until the queue has room
	`TLC_ASSERT(a_s1_hold, (v_s1 && !adv) |=> (v_s1 && $stable(char_s1) && $stable(end_s1)), "stalled byte lost")
	// every line end produces a closing result
	`TLC_ASSERT(a_eol_result, (adv && end_s1) |-> (push.count != 2'd0), "line end without result")
	// the queue never overflows
	`TLC_ASSERT_ALWAYS(a_q_bound, qstat.level <= QCNT_BITS'(QDEPTH), "result queue overflow")

endmodule

@@ hw/rtl/tlc_core.sv @@
// Tokenizer state and per-character classification logic
module tlc_core import tlc_pkg::*; #(
	parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] text_char,
	input  logic       line_end,
	output push_t      push
);

	typedef struct packed {
		logic                   in_quote;
		logic                   esc;
		logic                   begun;
		logic [DEPTH_BITS-1:0]  paren;
		logic [DEPTH_BITS-1:0]  brace;
		logic [LENGTH_BITS-1:0] len;
		logic [7:0]             first;
		logic                   num_like;
		logic                   pre;
		logic                   hex_seen;
		logic [3:0]             hex_cnt;
		logic [1:0]             per_cnt;
		logic [1:0]             sign_cnt;
		logic                   per_exp;
		logic                   stopped;
		logic [2:0]             kw;
	} st_t;

	typedef enum logic [1:0] {
		FEED_NONE,
		FEED_CHAR,
		FEED_END
	} feed_t;

	function automatic st_t tok_clear(st_t s);
		st_t t;
		t          = s;
		t.len      = '0;
		t.first    = '0;
		t.num_like = 1'b1;
		t.pre      = 1'b1;
		t.hex_seen = 1'b0;
		t.hex_cnt  = '0;
		t.per_cnt  = '0;
		t.sign_cnt = '0;
		t.per_exp  = 1'b0;
		t.stopped  = 1'b0;
		t.kw       = '1;
		return t;
	endfunction

	function automatic st_t st_reset();
		st_t t;
		t          = '0;
		t          = tok_clear(t);
		return t;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic st_t take_char(st_t s, logic [7:0] c);
		st_t  t;
		logic hex_reset;
		logic ok;
		logic lt4;
		logic lt5;
		t         = s;
		hex_reset = 1'b0;
		ok        = 1'b0;
		lt4       = (s.len < LENGTH_BITS'(4));
		lt5       = (s.len < LENGTH_BITS'(5));
		if (s.len == '0)
			t.first = c;
		if (!(lt4 && c == WORD_NULL[s.len[1:0]]))
			t.kw[0] = 1'b0;
		if (!(lt4 && c == WORD_TRUE[s.len[1:0]]))
			t.kw[1] = 1'b0;
		if (!(lt5 && c == WORD_FALSE[s.len[2:0]]))
			t.kw[2] = 1'b0;
		if (!s.stopped) begin
			if (c == ".") begin
				t.per_exp = 1'b1;
				if (s.per_cnt != 2'd3)
					t.per_cnt = s.per_cnt + 2'd1;
				if (t.per_cnt > 2'd1)
					t.num_like = 1'b0;
			end
			if (!s.hex_seen && (c == "e" || c == "E"))
				t.per_exp = 1'b1;
			if (s.pre && (c == "x" || c == "X")) begin
				t.hex_seen = 1'b1;
				t.hex_cnt  = '0;
				hex_reset  = 1'b1;
			end else if (s.pre && (c == "0" || c == "+" || c == "-")) begin
				if (c != "0") begin
					if (s.sign_cnt != 2'd3)
						t.sign_cnt = s.sign_cnt + 2'd1;
					if (t.sign_cnt > 2'd1)
						t.num_like = 1'b0;
				end
			end else begin
				ok = is_digit(c) || c == "." || c == "e" || c == "E" || c == "+" ||
					c == "-" || (s.hex_seen && ((c >= "a" && c <= "f") ||
					(c >= "A" && c <= "F")));
				t.pre = 1'b0;
				if (!ok) begin
					t.num_like = 1'b0;
					t.stopped  = 1'b1;
				end
			end
		end
		if (!hex_reset && t.hex_seen && t.hex_cnt != 4'hF)
			t.hex_cnt = t.hex_cnt + 4'd1;
		if (s.len != '1)
			t.len = s.len + LENGTH_BITS'(1);
		return t;
	endfunction

	function automatic class_t classify(st_t s);
		logic   num;
		class_t cls;
		num = s.num_like && !(s.hex_seen && s.hex_cnt > 4'd8);
		priority if (s.kw[0] && s.len == LENGTH_BITS'(4))
			cls = CLS_NULL;
		else if (num && (is_digit(s.first) || s.first == "+" || s.first == "-" ||
				s.first == ".") && (s.first != "." || s.len > LENGTH_BITS'(1)))
			cls = s.per_exp ? CLS_FLOAT : CLS_INT;
		else if (s.first == "(")
			cls = CLS_LIST;
		else if (s.first == "[")
			cls = CLS_VOCAB;
		else if (s.first == "{")
			cls = CLS_BLOB;
		else if (s.first != "\"" && s.kw[1] && s.len == LENGTH_BITS'(4))
			cls = CLS_TRUE;
		else if (s.first != "\"" && s.kw[2] && s.len == LENGTH_BITS'(5))
			cls = CLS_FALSE;
		else
			cls = CLS_STRING;
		return cls;
	endfunction

	function automatic st_t feed(st_t s, logic [7:0] ch, output feed_t r, output class_t cls);
		st_t  t;
		logic ws;
		t   = s;
		r   = FEED_NONE;
		cls = CLS_INT;
		ws  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
		if (s.esc) begin
			t.esc = 1'b0;
			t     = take_char(t, ch);
			r     = FEED_CHAR;
		end else begin
			if (!ws)
				t.begun = 1'b1;
			if (t.begun) begin
				if (ch == "\"")
					t.in_quote = ~t.in_quote;
				if (!t.in_quote) begin
					if (ch == "(")
						t.paren = t.paren + DEPTH_BITS'(1);
					if (ch == ")")
						t.paren = t.paren - DEPTH_BITS'(1);
					if (ch == "{")
						t.brace = t.brace + DEPTH_BITS'(1);
					if (ch == "}")
						t.brace = t.brace - DEPTH_BITS'(1);
				end
				if (ch == "\\") begin
					t.esc = 1'b1;
					t     = take_char(t, ch);
					r     = FEED_CHAR;
				end else if (!t.in_quote && (ws || ch == ",") && t.paren == '0 &&
						t.brace == '0) begin
					if (t.len != '0) begin
						cls = classify(t);
						r   = FEED_END;
					end
					t       = tok_clear(t);
					t.begun = 1'b0;
				end else begin
					t = take_char(t, ch);
					r = FEED_CHAR;
				end
			end
		end
		return t;
	endfunction

	st_t     state_q;
	st_t     st_a;
	st_t     st_b;
	st_t     st_next;
	feed_t   r_a;
	feed_t   r_b;
	class_t  cls_a;
	class_t  cls_b;
	result_t res_char;
	result_t res_line;

	always_comb begin
		st_a = feed(state_q, text_char, r_a, cls_a);
		// line end: an implicit space follows the last character
		st_b = feed(st_a, CH_SPACE, r_b, cls_b);

		res_char             = '0;
		res_char.item_kind   = (r_a == FEED_END) ? KIND_TOKEN_END : KIND_CHAR;
		res_char.token_char  = (r_a == FEED_CHAR) ? text_char : 8'd0;
		res_char.token_class = (r_a == FEED_END) ? cls_a : CLS_INT;

		res_line             = '0;
		res_line.item_kind   = (r_b == FEED_END) ? KIND_TOKEN_END : KIND_LINE_END;
		res_line.token_class = (r_b == FEED_END) ? cls_b : CLS_INT;
		res_line.end_of_line = 1'b1;
		res_line.balanced    = (st_b.paren == '0) && (st_b.brace == '0) && !st_b.in_quote;

		push.count = 2'((r_a != FEED_NONE)) + 2'(line_end);
		push.r0    = (r_a != FEED_NONE) ? res_char : res_line;
		push.r1    = res_line;

		st_next = line_end ? st_reset() : st_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= st_reset();
		else if (step)
			state_q <= st_next;
	end

endmodule

@@ hw/rtl/tlc_outq.sv @@
// Small result queue taking up to two results per cycle
module tlc_outq import tlc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  push_t   push,
	input  logic    rd_en,
	output logic    rd_valid,
	output result_t rd_data,
	output qstat_t  stat
);

	result_t              mem [QDEPTH];
	logic [QPTR_BITS-1:0] wp_q;
	logic [QPTR_BITS-1:0] rp_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic [QCNT_BITS-1:0] n_in;
	logic                 pop;

	assign n_in       = wr_en ? QCNT_BITS'(push.count) : '0;
	assign pop        = rd_en && rd_valid;
	assign rd_valid   = (cnt_q != '0);
	assign rd_data    = mem[rp_q];
	assign stat.level = cnt_q;
	assign stat.room2 = (cnt_q <= QCNT_BITS'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_en && push.count != 2'd0)
			mem[wp_q] <= push.r0;
		if (wr_en && push.count == 2'd2)
			mem[wp_q + QPTR_BITS'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_in[QPTR_BITS-1:0];
			rp_q  <= rp_q + QPTR_BITS'(pop);
			cnt_q <= cnt_q + n_in - QCNT_BITS'(pop);
		end
	end

endmodule

@@ tb/sv/tb_text_list_tokenizer_classifier.sv @@
// Self-checking testbench for the text list tokenizer and token classifier
module tb_text_list_tokenizer_classifier;
	import tlc_pkg::*;

	localparam int DEPTH_W     = 8;
	localparam int LEN_W       = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;

	localparam bit [39:0] KW_NULL  = "null";
	localparam bit [39:0] KW_TRUE  = "true";
	localparam bit [39:0] KW_FALSE = "false";

	typedef enum int {FED_NONE, FED_CHAR, FED_END} feed_t;

	logic clk;
	logic arst_n;

	tlc_in_if  chars_if();
	tlc_out_if results_if();

	text_list_tokenizer_classifier #(
		.DEPTH_BITS (DEPTH_W),
		.LENGTH_BITS(LEN_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.results(results_if)
	);

	result_t  expected_q[$];
	bit [7:0] line_q[$];

	int send_idle_pct = 7;
	int recv_idle_pct = 64;
	int fail_count    = 0;
	int chars_sent    = 0;
	int lines_sent    = 0;
	int results_seen  = 0;
	int tokens_seen   = 0;
	int cycle_cnt     = 0;

	// tokenizer state of the predictor
	bit               quoted, escaped, tok_open;
	bit [DEPTH_W-1:0] paren_lvl, brace_lvl;
	bit [LEN_W-1:0]   tok_len;
	bit [7:0]         lead_char;
	bit               numeric, preamble, hex_mode;
	bit [3:0]         hex_digits;
	bit [1:0]         periods, signs;
	bit               frac_or_exp, scan_done;
	bit [2:0]         word_hits;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_token();
		tok_len     = '0;
		lead_char   = 8'h00;
		numeric     = 1'b1;
		preamble    = 1'b1;
		hex_mode    = 1'b0;
		hex_digits  = '0;
		periods     = '0;
		signs       = '0;
		frac_or_exp = 1'b0;
		scan_done   = 1'b0;
		word_hits   = 3'b111;
	endfunction

	function automatic void reset_tokenizer();
		quoted    = 1'b0;
		escaped   = 1'b0;
		tok_open  = 1'b0;
		paren_lvl = '0;
		brace_lvl = '0;
		clear_token();
	endfunction

	function automatic bit is_digit(bit [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit word_hit(bit [39:0] w, int n, int idx, bit [7:0] c);
		if (idx >= n)
			return 1'b0;
		return c == w[8*(n-1-idx) +: 8];
	endfunction

	function automatic bit number_char(bit [7:0] c);
		return is_digit(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-" ||
			(hex_mode && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")));
	endfunction

	function automatic void take_char(bit [7:0] c);
		bit hex_restart;
		int idx;
		hex_restart = 1'b0;
		idx = tok_len;
		if (tok_len == 0)
			lead_char = c;
		if (!word_hit(KW_NULL, 4, idx, c))
			word_hits[0] = 1'b0;
		if (!word_hit(KW_TRUE, 4, idx, c))
			word_hits[1] = 1'b0;
		if (!word_hit(KW_FALSE, 5, idx, c))
			word_hits[2] = 1'b0;
		if (!scan_done) begin
			if (c == ".") begin
				frac_or_exp = 1'b1;
				if (periods != 2'd3)
					periods++;
				if (periods > 1)
					numeric = 1'b0;
			end
			if (!hex_mode && (c == "e" || c == "E"))
				frac_or_exp = 1'b1;
			if (preamble && (c == "x" || c == "X")) begin
				hex_mode    = 1'b1;
				hex_digits  = '0;
				hex_restart = 1'b1;
			end else if (preamble && (c == "0" || c == "+" || c == "-")) begin
				if (c != "0") begin
					if (signs != 2'd3)
						signs++;
					if (signs > 1)
						numeric = 1'b0;
				end
			end else begin
				preamble = 1'b0;
				if (!number_char(c)) begin
					numeric   = 1'b0;
					scan_done = 1'b1;
				end
			end
		end
		if (!hex_restart && hex_mode && hex_digits != 4'hF)
			hex_digits++;
		if (tok_len != '1)
			tok_len++;
	endfunction

	function automatic class_t token_kind_of();
		bit num;
		num = numeric && !(hex_mode && hex_digits > 8);
		if (word_hits[0] && tok_len == 4)
			return CLS_NULL;
		if (num && (is_digit(lead_char) || lead_char == "+" || lead_char == "-" ||
				lead_char == ".") && (lead_char != "." || tok_len > 1))
			return frac_or_exp ? CLS_FLOAT : CLS_INT;
		if (lead_char == "(")
			return CLS_LIST;
		if (lead_char == "[")
			return CLS_VOCAB;
		if (lead_char == "{")
			return CLS_BLOB;
		if (lead_char != "\"") begin
			if (word_hits[1] && tok_len == 4)
				return CLS_TRUE;
			if (word_hits[2] && tok_len == 5)
				return CLS_FALSE;
		end
		return CLS_STRING;
	endfunction

	function automatic feed_t feed(bit [7:0] c, output class_t cls);
		bit ws;
		feed_t fed;
		ws = c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
		cls = CLS_INT;
		if (escaped) begin
			escaped = 1'b0;
			take_char(c);
			return FED_CHAR;
		end
		if (!tok_open && !ws)
			tok_open = 1'b1;
		if (!tok_open)
			return FED_NONE;
		if (c == "\"")
			quoted = !quoted;
		if (!quoted) begin
			if (c == "(")
				paren_lvl++;
			if (c == ")")
				paren_lvl--;
			if (c == "{")
				brace_lvl++;
			if (c == "}")
				brace_lvl--;
		end
		if (c == "\\") begin
			escaped = 1'b1;
			take_char(c);
			return FED_CHAR;
		end
		if (!quoted && (ws || c == ",") && paren_lvl == 0 && brace_lvl == 0) begin
			fed = FED_NONE;
			if (tok_len > 0) begin
				cls = token_kind_of();
				fed = FED_END;
			end
			clear_token();
			tok_open = 1'b0;
			return fed;
		end
		take_char(c);
		return FED_CHAR;
	endfunction

	function automatic void expect_result(kind_t kind, bit [7:0] ch, class_t cls, bit eol,
			bit bal);
		result_t r;
		r.item_kind   = kind;
		r.token_char  = ch;
		r.token_class = cls;
		r.end_of_line = eol;
		r.balanced    = bal;
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic void predict_char(bit [7:0] ch, bit last);
		class_t cls;
		feed_t fed;
		bit bal;
		fed = feed(ch, cls);
		if (fed == FED_CHAR)
			expect_result(KIND_CHAR, ch, CLS_INT, 1'b0, 1'b0);
		else if (fed == FED_END)
			expect_result(KIND_TOKEN_END, 8'h00, cls, 1'b0, 1'b0);
		if (last) begin
			// implicit space closes the line
			fed = feed(CH_SPACE, cls);
			bal = paren_lvl == 0 && brace_lvl == 0 && !quoted;
			if (fed == FED_END)
				expect_result(KIND_TOKEN_END, 8'h00, cls, 1'b1, bal);
			else
				expect_result(KIND_LINE_END, 8'h00, CLS_INT, 1'b1, bal);
			reset_tokenizer();
		end
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			results_seen++;
			if (results_if.item_kind == KIND_TOKEN_END)
				tokens_seen++;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: item_kind %0d",
					results_if.item_kind);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (results_if.item_kind !== want.item_kind) begin
					$error("item_kind: expected %0d, got %0d", want.item_kind,
						results_if.item_kind);
					fail_count++;
				end
				if (results_if.token_char !== want.token_char) begin
					$error("token_char: expected %02h, got %02h", want.token_char,
						results_if.token_char);
					fail_count++;
				end
				if (results_if.token_class !== want.token_class) begin
					$error("token_class: expected %0d, got %0d", want.token_class,
						results_if.token_class);
					fail_count++;
				end
				if (results_if.end_of_line !== want.end_of_line) begin
					$error("end_of_line: expected %0d, got %0d", want.end_of_line,
						results_if.end_of_line);
					fail_count++;
				end
				if (results_if.balanced !== want.balanced) begin
					$error("balanced: expected %0d, got %0d", want.balanced,
						results_if.balanced);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("text_list_tokenizer_classifier test failed");
			$finish;
		end
	end

	task automatic send_char(bit [7:0] ch, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.text_char <= ch;
		chars_if.line_end  <= last;
		do
			@(posedge clk);
		while (!chars_if.ready);
		predict_char(ch, last);
		chars_sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_char(line_q[i], i == line_q.size() - 1);
		line_q.delete();
		lines_sent++;
	endtask

	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_q.size() != 0);
	endtask

	// line builders
	function automatic void add_byte(bit [7:0] c);
		line_q.insert(line_q.size(), c);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic void put_digits(int n);
		repeat (n)
			add_byte(8'h30 + 8'($urandom_range(9)));
	endfunction

	function automatic void put_hex(int n);
		string hex_set;
		hex_set = "0123456789abcdefABCDEF";
		repeat (n)
			add_byte(hex_set[$urandom_range(21)]);
	endfunction

	function automatic void put_sign();
		put_str($urandom_range(1) ? "+" : "-");
	endfunction

	function automatic void put_number();
		case ($urandom_range(11))
			0: put_digits($urandom_range(1, 4));
			1: begin
				put_sign();
				put_digits($urandom_range(1, 3));
			end
			2: begin
				put_digits($urandom_range(0, 3));
				put_str(".");
				put_digits($urandom_range(0, 3));
			end
			3: begin
				put_digits($urandom_range(1, 2));
				put_str($urandom_range(1) ? "e" : "E");
				if ($urandom_range(1))
					put_sign();
				put_digits($urandom_range(0, 2));
			end
			4: begin
				put_str(".");
				put_digits($urandom_range(0, 2));
			end
			5: begin
				if ($urandom_range(1))
					put_sign();
				put_str($urandom_range(1) ? "0x" : "0X");
				put_hex($urandom_range(1, 11));
			end
			6: begin
				put_str($urandom_range(1) ? "+-" : "--");
				put_digits($urandom_range(1, 2));
			end
			7: begin
				put_digits(1);
				put_str(".");
				put_digits(1);
				put_str(".");
				put_digits(1);
			end
			8: begin
				// preamble oddities: repeated zeros, x without a leading digit
				put_str($urandom_range(1) ? "00x1f" : "x12");
				put_hex($urandom_range(0, 2));
			end
			9: put_str($urandom_range(1) ? "...." : "+-+-1");
			10: begin
				put_digits($urandom_range(1, 2));
				add_byte(8'h61 + 8'($urandom_range(25)));
			end
			default: begin
				put_str("-0x");
				put_hex($urandom_range(7, 10));
				put_str("e1");
			end
		endcase
	endfunction

	function automatic void put_keyword();
		string words[10];
		words = '{"null", "true", "false", "nul", "nulls", "True", "fals",
			"\"true\"", "xnull", "falsey"};
		if ($urandom_range(1))
			put_str(words[$urandom_range(2)]);
		else
			put_str(words[$urandom_range(9)]);
	endfunction

	function automatic void put_quoted();
		put_str("\"");
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(5))
				0: put_str(" ");
				1: put_str(",");
				2: put_str("(");
				3: put_str("\\\"");
				default: add_byte(8'h61 + 8'($urandom_range(25)));
			endcase
		end
		if ($urandom_range(9) != 0)
			put_str("\"");
	endfunction

	function automatic void put_escape();
		bit [7:0] picks[6];
		picks = '{CH_SPACE, 8'h22, 8'h28, 8'h5C, 8'h2C, 8'h7B};
		if ($urandom_range(1))
			put_str("ab");
		put_str("\\");
		if ($urandom_range(1))
			add_byte(picks[$urandom_range(5)]);
		else
			add_byte(8'($urandom_range(255)));
	endfunction

	function automatic void put_atom();
		case ($urandom_range(9))
			0, 1, 2, 3: put_number();
			4, 5: put_keyword();
			6: put_quoted();
			7: repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(255)));
			8: put_escape();
			default: repeat ($urandom_range(1, 6)) add_byte(8'h41 + 8'($urandom_range(57)));
		endcase
	endfunction

	function automatic void put_sep();
		bit [7:0] seps[5];
		seps = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, 8'h2C};
		repeat ($urandom_range(1, 2))
			add_byte(seps[$urandom_range(4)]);
	endfunction

	function automatic void put_group();
		int which;
		string opens, closes;
		opens  = "([{";
		closes = ")]}";
		which  = $urandom_range(2);
		add_byte(opens[which]);
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(2) == 0)
				put_sep();
			put_atom();
			if ($urandom_range(1))
				put_str($urandom_range(1) ? " " : ",");
		end
		case ($urandom_range(9))
			0: ;
			1: begin
				add_byte(closes[which]);
				add_byte(closes[$urandom_range(2)]);
			end
			default: add_byte(closes[which]);
		endcase
	endfunction

	function automatic void build_line();
		case ($urandom_range(19))
			0: put_sep();
			1, 2: repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
			default: begin
				if ($urandom_range(3) == 0)
					put_sep();
				for (int i = $urandom_range(1, 5); i > 0; i--) begin
					if ($urandom_range(3) == 0)
						put_group();
					else
						put_atom();
					if (i > 1)
						put_sep();
				end
				if ($urandom_range(3) == 0)
					put_sep();
			end
		endcase
	endfunction

	task automatic test_directed();
		// leading tab, int, float, empty token between commas, open paren at line end
		put_str("\t1 .e,,(");
		send_line();
		// backslash on the last byte: token dropped
		put_str("[x\\");
		send_line();
		// quoted string with a space, blob holding the top byte
		put_str("\"a b\" {");
		add_byte(8'hFF);
		put_str("}");
		send_line();
		put_str("null");
		send_line();
		put_str(" ");
		send_line();
		wait_drained();
	endtask

	task automatic test_random(int s_pct, int r_pct, int n_chars);
		int target;
		target        = chars_sent + n_chars;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		while (chars_sent < target) begin
			build_line();
			send_line();
			if ($urandom_range(24) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	task automatic test_wrap_and_length();
		// paren depth wraps back to zero, so the comma ends a saturated-length token
		repeat (256) put_str("(");
		put_str(",9");
		send_line();
		repeat (300) put_str("7");
		send_line();
		repeat (256) put_str("{");
		put_str(" x");
		send_line();
		wait_drained();
	endtask

	initial begin
		arst_n                = 1'b0;
		chars_if.valid        = 1'b0;
		chars_if.text_char    = 8'h00;
		chars_if.line_end     = 1'b0;
		results_if.ready      = 1'b0;
		reset_tokenizer();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(7, 64, 320);
		test_wrap_and_length();
		test_random(64, 7, 320);
		test_random(0, 0, 320);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d characters in %0d lines; checked %0d results, %0d token ends,",
			chars_sent, lines_sent, results_seen, tokens_seen);
		$display("over quoting, escapes, depth wrap, long tokens and three stall mixes");
		if (fail_count == 0)
			$display("text_list_tokenizer_classifier test passed");
		else
			$display("text_list_tokenizer_classifier test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tlc_pkg.sv
hw/rtl/tlc_if.sv
hw/rtl/tlc_core.sv
hw/rtl/tlc_outq.sv
hw/rtl/text_list_tokenizer_classifier.sv
tb/sv/tb_text_list_tokenizer_classifier.sv
